// ===== rtl/wcst_pkg.sv =====
// shared types, constants and codes for the wait continuation slot table
`timescale 1ns / 1ps
package wcst_pkg;
  localparam int SEND_SLOTS = 16;
  localparam int RECV_SLOTS = 16;
  localparam int SIDX_W = (SEND_SLOTS > 1) ? $clog2(SEND_SLOTS) : 1;
  localparam int RIDX_W = (RECV_SLOTS > 1) ? $clog2(RECV_SLOTS) : 1;
  localparam int SCNT_W = $clog2(SEND_SLOTS + 1);
  localparam int RCNT_W = $clog2(RECV_SLOTS + 1);

  typedef enum logic [3:0] {
    K_ARM_SEND = 4'd0, K_TAKE_SEND = 4'd1, K_CANCEL_SEND = 4'd2,
    K_ARM_RECV = 4'd3, K_TAKE_RECV = 4'd4, K_CANCEL_RECV = 4'd5,
    K_EXPIRE = 4'd6, K_RELEASE = 4'd7, K_PROBE = 4'd8
  } kind_t;

  typedef enum logic [3:0] {
    ST_OK = 4'd0, ST_BAD_THREAD = 4'd1, ST_BAD_EPOCH = 4'd2, ST_BAD_CAP = 4'd3,
    ST_BAD_ADDR = 4'd4, ST_ALREADY = 4'd5, ST_EXHAUSTED = 4'd6,
    ST_NOT_ARMED = 4'd7, ST_STALE = 4'd8
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN_SEND, S_SCAN_RECV, S_APPLY, S_RESCAN, S_DONE
  } state_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] thread_id;
    logic [31:0] epoch;
    logic        epoch_active;
    logic [31:0] capability;
    logic [63:0] buffer_address;
    logic [63:0] time_ns;
  } req_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [15:0] taken_thread;
    logic [31:0] taken_epoch;
    logic [31:0] taken_capability;
    logic [63:0] taken_address;
    logic [63:0] taken_deadline;
    logic        send_is_armed;
    logic        receive_is_armed;
    logic [5:0]  occupied_count;
    logic [63:0] earliest_deadline;
  } rsp_t;
endpackage

// ===== rtl/wcst_if.sv =====
// valid/ready channel interface carrying one payload
`timescale 1ns / 1ps
interface wcst_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/wait_continuation_slot_table.sv =====
// wait continuation slot table top level: sequencer, slot stores and one scan unit
//
//  channel | dir | payload
//  in_     | in  | kind, thread_id, epoch, epoch_active, capability, buffer_address, time_ns
//  out_    | out | status, taken_*, armed flags, occupied_count, earliest_deadline
//
// one transaction walks the send slots (send ops and release) and the receive
// slots one a cycle through the compare logic, then applies the change
// and walks the receive slots again to recompute the earliest deadline
// rst_n synchronous active low clears valid bits, occupancy and control
// in_ready is low while a transaction is in work or its result waits on out_
`timescale 1ns / 1ps
module wait_continuation_slot_table (
  input logic clk,
  input logic rst_n,
  wcst_if.sink   in_ch,
  wcst_if.source out_ch
);
  import wcst_pkg::*;

  state_t state_r, state_nxt;
  req_t   req_r;
  rsp_t   rsp_r;
  logic [SCNT_W-1:0] sidx_r;
  logic [RCNT_W-1:0] ridx_r;

  // slot stores
  logic [SEND_SLOTS-1:0] s_val_r;
  logic [15:0] s_own [SEND_SLOTS];
  logic [31:0] s_ep  [SEND_SLOTS];
  logic [63:0] s_adr [SEND_SLOTS];
  logic [RECV_SLOTS-1:0] r_val_r;
  logic [15:0] r_own [RECV_SLOTS];
  logic [31:0] r_ep  [RECV_SLOTS];
  logic [31:0] r_cap [RECV_SLOTS];
  logic [63:0] r_adr [RECV_SLOTS];
  logic [63:0] r_dl  [RECV_SLOTS];
  logic [5:0]  occ_r, occ_nxt;

  // scan results
  logic s_hit_r, s_free_r, r_hit_r, r_free_r, x_hit_r, r_armed_r;
  logic [SIDX_W-1:0] s_hidx_r, s_fidx_r;
  logic [RIDX_W-1:0] r_hidx_r, r_fidx_r, x_idx_r;
  logic [15:0] x_own_r;
  logic [63:0] earl_r;

  logic [SIDX_W-1:0] si;
  logic [RIDX_W-1:0] ri;
  logic tid_ok, epoch_ok, s_match, r_match, expired, dl_less;
  kind_t k;

  // decisions of the apply step
  logic s_arm_en, r_arm_en, s_free_en, r_free_en;
  logic [RIDX_W-1:0] r_sel;
  rsp_t rsp_apply_nxt, rsp_done_nxt;

  assign si = sidx_r[SIDX_W-1:0];
  assign ri = ridx_r[RIDX_W-1:0];
  assign k = kind_t'(req_r.kind);
  assign tid_ok = req_r.thread_id != 16'd0;
  assign epoch_ok = (req_r.epoch != 32'd0) && req_r.epoch_active;
  // the compare logic: one slot of one table per cycle
  assign s_match = s_val_r[si] && tid_ok && (s_own[si] == req_r.thread_id);
  assign r_match = r_val_r[ri] && tid_ok && (r_own[ri] == req_r.thread_id);
  assign expired = r_val_r[ri] && (r_dl[ri] != 64'd0) && (req_r.time_ns >= r_dl[ri]);
  assign dl_less = r_val_r[ri] && (r_dl[ri] != 64'd0) &&
                   ((earl_r == 64'd0) || (r_dl[ri] < earl_r));

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_DONE);
  assign out_ch.data = rsp_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_ch.valid) state_nxt = S_SCAN_SEND;
      S_SCAN_SEND: if (sidx_r == SCNT_W'(SEND_SLOTS - 1)) state_nxt = S_SCAN_RECV;
      S_SCAN_RECV: if (ridx_r == RCNT_W'(RECV_SLOTS - 1)) state_nxt = S_APPLY;
      S_APPLY: state_nxt = S_RESCAN;
      S_RESCAN: if (ridx_r == RCNT_W'(RECV_SLOTS - 1)) state_nxt = S_DONE;
      S_DONE: if (out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // apply step: status, taken entry and which slot changes, from the scan results
  always_comb begin
    rsp_apply_nxt = '0;  // status ok, taken fields zero
    s_arm_en = 1'b0;
    r_arm_en = 1'b0;
    s_free_en = 1'b0;
    r_free_en = 1'b0;
    r_sel = (k == K_EXPIRE) ? x_idx_r : r_hidx_r;
    priority case (k)
      K_ARM_SEND, K_ARM_RECV: begin
        if (!tid_ok) rsp_apply_nxt.status = ST_BAD_THREAD;
        else if (!epoch_ok) rsp_apply_nxt.status = ST_BAD_EPOCH;
        else if (k == K_ARM_RECV && req_r.capability == 32'd0)
          rsp_apply_nxt.status = ST_BAD_CAP;
        else if (req_r.buffer_address == 64'd0) rsp_apply_nxt.status = ST_BAD_ADDR;
        else if (k == K_ARM_SEND) begin
          if (s_hit_r) rsp_apply_nxt.status = ST_ALREADY;
          else if (!s_free_r) rsp_apply_nxt.status = ST_EXHAUSTED;
          else s_arm_en = 1'b1;
        end else begin
          if (r_hit_r) rsp_apply_nxt.status = ST_ALREADY;
          else if (!r_free_r) rsp_apply_nxt.status = ST_EXHAUSTED;
          else r_arm_en = 1'b1;
        end
      end
      K_TAKE_SEND, K_CANCEL_SEND: begin
        if (!s_hit_r) rsp_apply_nxt.status = ST_NOT_ARMED;
        else begin
          // the slot goes even when the epoch turns out stale
          s_free_en = 1'b1;
          if (k == K_TAKE_SEND) begin
            if (!epoch_ok || s_ep[s_hidx_r] != req_r.epoch) rsp_apply_nxt.status = ST_STALE;
            else begin
              rsp_apply_nxt.taken_thread = s_own[s_hidx_r];
              rsp_apply_nxt.taken_epoch = s_ep[s_hidx_r];
              rsp_apply_nxt.taken_address = s_adr[s_hidx_r];
            end
          end
        end
      end
      K_TAKE_RECV, K_CANCEL_RECV, K_EXPIRE: begin
        if ((k == K_EXPIRE) ? !x_hit_r : !r_hit_r) rsp_apply_nxt.status = ST_NOT_ARMED;
        else begin
          r_free_en = 1'b1;
          // expiry has no epoch check
          if (k == K_TAKE_RECV && (!epoch_ok || r_ep[r_sel] != req_r.epoch))
            rsp_apply_nxt.status = ST_STALE;
          else if (k != K_CANCEL_RECV) begin
            rsp_apply_nxt.taken_thread = r_own[r_sel];
            rsp_apply_nxt.taken_epoch = r_ep[r_sel];
            rsp_apply_nxt.taken_capability = r_cap[r_sel];
            rsp_apply_nxt.taken_address = r_adr[r_sel];
            rsp_apply_nxt.taken_deadline = r_dl[r_sel];
          end
        end
      end
      K_RELEASE: begin
        s_free_en = s_hit_r;
        r_free_en = r_hit_r;
      end
      default: ;
    endcase

    // both frees can land together; occupancy saturates at zero
    if (s_arm_en || r_arm_en) occ_nxt = occ_r + 6'd1;
    else if (s_free_en && r_free_en) occ_nxt = (occ_r > 6'd1) ? occ_r - 6'd2 : 6'd0;
    else if ((s_free_en || r_free_en) && occ_r != 6'd0) occ_nxt = occ_r - 6'd1;
    else occ_nxt = occ_r;
  end

  // result once the rescan reaches its last slot
  always_comb begin
    rsp_done_nxt = rsp_r;
    rsp_done_nxt.receive_is_armed = r_armed_r || r_match;
    rsp_done_nxt.earliest_deadline = dl_less ? r_dl[ri] : earl_r;
    rsp_done_nxt.occupied_count = occ_r;
    // the send flag after the step follows from the send scan and the operation
    rsp_done_nxt.send_is_armed = (s_hit_r && k != K_TAKE_SEND && k != K_CANCEL_SEND &&
                                  k != K_RELEASE) ||
                                 (k == K_ARM_SEND && rsp_r.status == ST_OK);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  // scan registers, stores and result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_val_r <= '0;
      r_val_r <= '0;
      occ_r <= '0;
      sidx_r <= '0;
      ridx_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) req_r <= in_ch.data;
          sidx_r <= '0;
          ridx_r <= '0;
          s_hit_r <= 1'b0; s_free_r <= 1'b0;
          r_hit_r <= 1'b0; r_free_r <= 1'b0; x_hit_r <= 1'b0;
          r_armed_r <= 1'b0;
          x_own_r <= '0;
        end
        S_SCAN_SEND: begin
          if (s_match && !s_hit_r) begin
            s_hit_r <= 1'b1; s_hidx_r <= si;
          end
          if (!s_val_r[si] && !s_free_r) begin
            s_free_r <= 1'b1; s_fidx_r <= si;
          end
          sidx_r <= sidx_r + 1'b1;
        end
        S_SCAN_RECV: begin
          if (r_match && !r_hit_r) begin
            r_hit_r <= 1'b1; r_hidx_r <= ri;
          end
          if (!r_val_r[ri] && !r_free_r) begin
            r_free_r <= 1'b1; r_fidx_r <= ri;
          end
          if (expired && (!x_hit_r || r_own[ri] < x_own_r)) begin
            x_hit_r <= 1'b1; x_idx_r <= ri; x_own_r <= r_own[ri];
          end
          ridx_r <= (ridx_r == RCNT_W'(RECV_SLOTS - 1)) ? '0 : ridx_r + 1'b1;
        end
        S_APPLY: begin
          rsp_r <= rsp_apply_nxt;
          earl_r <= '0;
          occ_r <= occ_nxt;
          if (s_arm_en) begin
            s_val_r[s_fidx_r] <= 1'b1;
            s_own[s_fidx_r] <= req_r.thread_id;
            s_ep[s_fidx_r] <= req_r.epoch;
            s_adr[s_fidx_r] <= req_r.buffer_address;
          end
          if (r_arm_en) begin
            r_val_r[r_fidx_r] <= 1'b1;
            r_own[r_fidx_r] <= req_r.thread_id;
            r_ep[r_fidx_r] <= req_r.epoch;
            r_cap[r_fidx_r] <= req_r.capability;
            r_adr[r_fidx_r] <= req_r.buffer_address;
            r_dl[r_fidx_r] <= req_r.time_ns;
          end
          if (s_free_en) s_val_r[s_hidx_r] <= 1'b0;
          if (r_free_en) r_val_r[r_sel] <= 1'b0;
        end
        S_RESCAN: begin
          if (dl_less) earl_r <= r_dl[ri];
          ridx_r <= ridx_r + 1'b1;
          if (r_match) r_armed_r <= 1'b1;
          if (ridx_r == RCNT_W'(RECV_SLOTS - 1)) rsp_r <= rsp_done_nxt;
        end
        S_DONE: ;
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= 6'(SEND_SLOTS + RECV_SLOTS)) else $error("occupancy out of range");
  a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready) else $error("ready while result pending");
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> state_r == S_SCAN_SEND) else $error("accept lost");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid && $stable(rsp_r))
    else $error("result changed while stalled");
`endif
endmodule

// ===== sim/wait_continuation_slot_table_chk.sv =====
// checker: watches both channels, predicts each result of the slot table and compares
`timescale 1ns / 1ps
module wait_continuation_slot_table_chk
  import wcst_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_ready,
  input  req_t in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  rsp_t out_data,
  output int   fail_count,
  output int   pending_count,
  output int   result_count,
  output int   stale_seen,
  output int   expire_seen,
  output int   full_seen
);
  logic        snd_busy [SEND_SLOTS];
  logic [15:0] snd_tid  [SEND_SLOTS];
  logic [31:0] snd_ep   [SEND_SLOTS];
  logic [63:0] snd_addr [SEND_SLOTS];
  logic        rcv_busy [RECV_SLOTS];
  logic [15:0] rcv_tid  [RECV_SLOTS];
  logic [31:0] rcv_ep   [RECV_SLOTS];
  logic [31:0] rcv_cap  [RECV_SLOTS];
  logic [63:0] rcv_addr [RECV_SLOTS];
  logic [63:0] rcv_dl   [RECV_SLOTS];
  int          slots_used;
  rsp_t        expected_rsp [$];

  function automatic int send_slot_of(logic [15:0] t);
    if (t == 0) return -1;
    for (int i = 0; i < SEND_SLOTS; i++)
      if (snd_busy[i] && snd_tid[i] == t) return i;
    return -1;
  endfunction

  function automatic int recv_slot_of(logic [15:0] t);
    if (t == 0) return -1;
    for (int i = 0; i < RECV_SLOTS; i++)
      if (rcv_busy[i] && rcv_tid[i] == t) return i;
    return -1;
  endfunction

  function automatic logic [63:0] soonest_deadline();
    logic [63:0] e;
    e = 0;
    for (int i = 0; i < RECV_SLOTS; i++)
      if (rcv_busy[i] && rcv_dl[i] != 0 && (e == 0 || rcv_dl[i] < e)) e = rcv_dl[i];
    return e;
  endfunction

  // applies one request to the shadow tables and returns the result it must give
  function automatic rsp_t apply_request(req_t r);
    rsp_t o;
    logic ep_ok;
    int s;
    o = '0;
    o.status = ST_OK;
    ep_ok = (r.epoch != 0) && r.epoch_active;
    case (r.kind)
      K_ARM_SEND, K_ARM_RECV: begin
        if (r.thread_id == 0) o.status = ST_BAD_THREAD;
        else if (!ep_ok) o.status = ST_BAD_EPOCH;
        else if (r.kind == K_ARM_RECV && r.capability == 0) o.status = ST_BAD_CAP;
        else if (r.buffer_address == 0) o.status = ST_BAD_ADDR;
        else if (r.kind == K_ARM_SEND) begin
          if (send_slot_of(r.thread_id) >= 0) o.status = ST_ALREADY;
          else begin
            o.status = ST_EXHAUSTED;
            for (int i = 0; i < SEND_SLOTS; i++)
              if (!snd_busy[i]) begin
                snd_busy[i] = 1; snd_tid[i] = r.thread_id; snd_ep[i] = r.epoch;
                snd_addr[i] = r.buffer_address; slots_used++; o.status = ST_OK;
                break;
              end
          end
        end else begin
          if (recv_slot_of(r.thread_id) >= 0) o.status = ST_ALREADY;
          else begin
            o.status = ST_EXHAUSTED;
            for (int i = 0; i < RECV_SLOTS; i++)
              if (!rcv_busy[i]) begin
                rcv_busy[i] = 1; rcv_tid[i] = r.thread_id; rcv_ep[i] = r.epoch;
                rcv_cap[i] = r.capability; rcv_addr[i] = r.buffer_address;
                rcv_dl[i] = r.time_ns; slots_used++; o.status = ST_OK;
                break;
              end
          end
        end
      end
      K_TAKE_SEND, K_CANCEL_SEND: begin
        s = send_slot_of(r.thread_id);
        if (s < 0) o.status = ST_NOT_ARMED;
        else begin
          snd_busy[s] = 0;
          if (slots_used > 0) slots_used--;
          if (r.kind == K_TAKE_SEND) begin
            // slot is gone even when the epoch turns out stale
            if (!ep_ok || snd_ep[s] != r.epoch) o.status = ST_STALE;
            else begin
              o.taken_thread = snd_tid[s]; o.taken_epoch = snd_ep[s];
              o.taken_address = snd_addr[s];
            end
          end
        end
      end
      K_TAKE_RECV, K_CANCEL_RECV, K_EXPIRE: begin
        s = -1;
        if (r.kind == K_EXPIRE) begin
          for (int i = 0; i < RECV_SLOTS; i++)
            if (rcv_busy[i] && rcv_dl[i] != 0 && r.time_ns >= rcv_dl[i])
              if (s < 0 || rcv_tid[i] < rcv_tid[s]) s = i;
        end else s = recv_slot_of(r.thread_id);
        if (s < 0) o.status = ST_NOT_ARMED;
        else begin
          rcv_busy[s] = 0;
          if (slots_used > 0) slots_used--;
          if (r.kind == K_TAKE_RECV && (!ep_ok || rcv_ep[s] != r.epoch))
            o.status = ST_STALE;
          else if (r.kind != K_CANCEL_RECV) begin
            o.taken_thread = rcv_tid[s]; o.taken_epoch = rcv_ep[s];
            o.taken_capability = rcv_cap[s]; o.taken_address = rcv_addr[s];
            o.taken_deadline = rcv_dl[s];
          end
        end
      end
      K_RELEASE: begin
        s = send_slot_of(r.thread_id);
        if (s >= 0) begin snd_busy[s] = 0; if (slots_used > 0) slots_used--; end
        s = recv_slot_of(r.thread_id);
        if (s >= 0) begin rcv_busy[s] = 0; if (slots_used > 0) slots_used--; end
      end
      default: ;
    endcase
    o.send_is_armed = send_slot_of(r.thread_id) >= 0;
    o.receive_is_armed = recv_slot_of(r.thread_id) >= 0;
    o.occupied_count = slots_used[5:0];
    o.earliest_deadline = soonest_deadline();
    return o;
  endfunction

  always @(posedge clk) begin
    rsp_t e;
    if (!rst_n) begin
      for (int i = 0; i < SEND_SLOTS; i++) snd_busy[i] = 0;
      for (int i = 0; i < RECV_SLOTS; i++) rcv_busy[i] = 0;
      slots_used = 0;
      fail_count <= 0; result_count <= 0; pending_count <= 0;
      stale_seen <= 0; expire_seen <= 0; full_seen <= 0;
      expected_rsp.delete();
    end else begin
      if (out_valid && out_ready) begin
        result_count <= result_count + 1;
        if (expected_rsp.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %p", out_data);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_rsp.pop_front();
          if (out_data !== e) begin
            if (fail_count < 10)
              $display("mismatch at %0t\n  exp %p\n  got %p", $realtime, e, out_data);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready) begin
        e = apply_request(in_data);
        if (e.status == ST_STALE) stale_seen <= stale_seen + 1;
        if (e.status == ST_EXHAUSTED) full_seen <= full_seen + 1;
        if (in_data.kind == K_EXPIRE && e.status == ST_OK) expire_seen <= expire_seen + 1;
        expected_rsp.push_back(e);
      end
      pending_count <= expected_rsp.size();
    end
  end
endmodule

// ===== sim/wait_continuation_slot_table_tb.sv =====
// testbench top: clock, reset, request stimulus, result stalls and verdict
`timescale 1ns / 1ps
module wait_continuation_slot_table_tb;
  import wcst_pkg::*;

  localparam int RANDOM_ITEMS = 1750;
  localparam int CALM_ITEMS   = 200;   // tail of the run with no idling
  localparam int STALL_LIMIT  = 2000;  // idle cycles before the watchdog fires
  localparam int DRAIN_CYCLES = 120;   // well beyond the length of one transaction

  logic clk;
  logic rst_n;
  int   fail_count, pending_count, result_count;
  int   stale_seen, expire_seen, full_seen;
  int   idle_cycles;
  logic calm;

  wcst_if #(.T(req_t)) in_ch ();
  wcst_if #(.T(rsp_t)) out_ch ();

  wait_continuation_slot_table dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  wait_continuation_slot_table_chk chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .fail_count(fail_count), .pending_count(pending_count),
    .result_count(result_count), .stale_seen(stale_seen),
    .expire_seen(expire_seen), .full_seen(full_seen)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // small pool of thread ids so that arms, takes and duplicates collide often
  function automatic logic [15:0] pick_thread();
    case ($urandom_range(0, 19))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(1, 24));
    endcase
  endfunction

  function automatic logic [31:0] pick_epoch();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom;
      default: return 32'($urandom_range(1, 3));
    endcase
  endfunction

  function automatic logic [63:0] pick_wide();
    case ($urandom_range(0, 9))
      0:       return 64'd0;
      1:       return '1;
      2:       return 64'($urandom_range(1, 300));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic req_t make_req(kind_t k, logic [15:0] t, logic [31:0] ep,
                                    logic act, logic [31:0] cap,
                                    logic [63:0] addr, logic [63:0] tns);
    req_t r;
    r.kind = k; r.thread_id = t; r.epoch = ep; r.epoch_active = act;
    r.capability = cap; r.buffer_address = addr; r.time_ns = tns;
    return r;
  endfunction

  // mostly well-formed requests with random content, some noise
  function automatic req_t random_req();
    req_t r;
    int   mix;
    mix = $urandom_range(0, 99);
    r.kind = (mix < 22) ? K_ARM_SEND : (mix < 44) ? K_ARM_RECV :
             (mix < 54) ? K_TAKE_SEND : (mix < 64) ? K_TAKE_RECV :
             (mix < 69) ? K_CANCEL_SEND : (mix < 74) ? K_CANCEL_RECV :
             (mix < 86) ? K_EXPIRE : (mix < 92) ? K_RELEASE :
             (mix < 97) ? K_PROBE : 4'($urandom_range(9, 15));
    r.thread_id = pick_thread();
    r.epoch = pick_epoch();
    r.epoch_active = ($urandom_range(0, 9) != 0);
    r.capability = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom;
    r.buffer_address = ($urandom_range(0, 14) == 0) ? 64'd0 : pick_wide();
    r.time_ns = pick_wide();
    return r;
  endfunction

  // sender: valid stays up after the transaction until the next one or an idle gap
  task automatic send_req(req_t r);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= r;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // drops valid after the last transaction of a stretch
  task automatic stop_sending();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // receiver stalls in bursts; none in the closing part
  initial begin
    int burst;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        burst = $urandom_range(1, 10);
        out_ch.ready <= 1'b0;
        repeat (burst) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // watchdog on cycles with no transaction on either channel
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("wait_continuation_slot_table_tb failed");
        $finish;
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    calm  = 1'b0;
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: check order of arm, duplicates, stale takes, expire, release
    send_req(make_req(K_PROBE, 16'd0, 0, 0, 0, 0, 0));
    send_req(make_req(K_ARM_SEND, 16'd0, 1, 1, 1, 1, 0));          // bad thread
    send_req(make_req(K_ARM_SEND, 16'd5, 0, 1, 1, 1, 0));          // bad epoch, zero
    send_req(make_req(K_ARM_SEND, 16'd5, 7, 0, 1, 1, 0));          // bad epoch, inactive
    send_req(make_req(K_ARM_RECV, 16'd5, 7, 1, 0, 1, 0));          // bad capability
    send_req(make_req(K_ARM_RECV, 16'd5, 7, 1, 9, 0, 0));          // bad address
    send_req(make_req(K_ARM_SEND, 16'hFFFF, '1, 1, '1, '1, '1));
    send_req(make_req(K_ARM_SEND, 16'hFFFF, 3, 1, 1, 5, 0));       // already armed
    send_req(make_req(K_TAKE_SEND, 16'hFFFF, '1, 1, 0, 0, 0));
    send_req(make_req(K_ARM_SEND, 16'd5, 7, 1, 0, 8, 0));
    send_req(make_req(K_TAKE_SEND, 16'd5, 6, 1, 0, 0, 0));         // stale, slot freed
    send_req(make_req(K_TAKE_SEND, 16'd0, 6, 1, 0, 0, 0));         // thread zero
    send_req(make_req(K_ARM_RECV, 16'd9, '1, 1, '1, '1, '1));
    send_req(make_req(K_ARM_RECV, 16'd4, 2, 1, 3, 4, 100));
    send_req(make_req(K_ARM_RECV, 16'd2, 2, 1, 3, 4, 0));          // unbounded
    send_req(make_req(K_EXPIRE, 16'd0, 0, 0, 0, 0, 99));           // nothing expired
    send_req(make_req(K_EXPIRE, 16'd0, 0, 0, 0, 0, 100));          // deadline reached
    send_req(make_req(K_TAKE_RECV, 16'd9, '1, 0, 0, 0, 0));        // stale, inactive
    send_req(make_req(K_ARM_SEND, 16'd2, 1, 1, 0, 1, 0));
    send_req(make_req(K_RELEASE, 16'd2, 0, 0, 0, 0, 0));
    send_req(make_req(K_CANCEL_RECV, 16'd2, 0, 0, 0, 0, 0));       // already released
    send_req(make_req(K_CANCEL_SEND, 16'd3, 0, 0, 0, 0, 0));
    send_req(make_req(kind_t'(4'd15), 16'd1, 0, 0, 0, 0, 0));      // unknown kind
    // fill the send table past capacity
    for (int i = 1; i <= SEND_SLOTS + 1; i++)
      send_req(make_req(K_ARM_SEND, 16'(100 + i), 1, 1, 0, 64'(i), 0));
    stop_sending();

    // hold off until the block has answered everything so far
    while (pending_count != 0) @(posedge clk);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      send_req(random_req());
    end
    stop_sending();

    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d results: %0d stale takes, %0d expiries, %0d full-table arms",
             result_count, stale_seen, expire_seen, full_seen);
    if (fail_count == 0) begin
      $display("wait_continuation_slot_table_tb passed");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("wait_continuation_slot_table_tb failed");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/wcst_pkg.sv
rtl/wcst_if.sv
rtl/wait_continuation_slot_table.sv
sim/wait_continuation_slot_table_chk.sv
sim/wait_continuation_slot_table_tb.sv
